>>> rtl/sorted_key_index_table_assert.svh
// Assertion macros for the sorted key index table
`ifndef SORTED_KEY_INDEX_TABLE_ASSERT_SVH
`define SORTED_KEY_INDEX_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define SKIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define SKIT_NEVER(label, expr, msg) \
    `SKIT_ASSERT(label, !(expr), msg)

`else

`define SKIT_ASSERT(label, prop, msg)

`define SKIT_NEVER(label, expr, msg)

`endif

`endif

>>> rtl/skit_pkg.sv
// Shared types, constants and functions for the sorted key index table
package skit_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 64;
    localparam int ADDR_W    = 31;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
        logic              cmp;
        logic              ins;
        logic              rem;
    } t_cell_ctrl;

    // clear everything from the first zero byte on; only the top KEY_BYTES bytes count
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic             live;
        logic [7:0]       byte_v;
        res  = '0;
        live = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++) begin
            byte_v = k[KEY_W-1-8*b -: 8];
            if (byte_v == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                res[KEY_W-1-8*b -: 8] = byte_v;
            end
        end
        return res;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] c);
        logic [OUT_CNT_W-1:0] res;
        res = '0;
        for (int b = 0; b < OUT_CNT_W; b++) begin
            if (b < CNT_W) begin
                res[b] = c[b];
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/sorted_key_index_table.sv
// Top level of the sorted key index table: control, fill count and the chain of cells
//
// Command interface. A transaction is accepted on a rising edge with i_start high
// and o_busy low; i_func selects insert, remove or search, i_key is the packed
// key and i_record_address the address stored on insert. Every transaction
// gives exactly one result, shown for one cycle with o_done high on o_status,
// o_found_address and o_entry_count. The receiver cannot stall.
// The accepting edge registers the normalised key; in the next cycle every cell
// compares its key in parallel and registers the outcome; in the cycle after
// that the match is resolved, and on the edge ending it the cells shift left
// or right by one slot and the result is registered. o_busy is high only in
// the compare cycle, so a new transaction can be taken while the previous one
// is resolved. Reset (synchronous, active low) empties the table and sets
// unique_keys; cell contents are not cleared, as slots beyond the fill count
// are never read. i_cfg_we writes unique_keys from i_cfg_wdata; the user must
// do so only while the block is idle, which the block itself does not enforce.
module sorted_key_index_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_func,
    input  logic [skit_pkg::KEY_W-1:0]  i_key,
    input  logic [skit_pkg::ADDR_W-1:0] i_record_address,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [skit_pkg::ADDR_W-1:0] o_found_address,
    output logic [6:0]                  o_entry_count
);
    import skit_pkg::*;

    logic              r_unique;
    logic              r_cmp;
    logic              r_apply;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    t_func             r_func;
    logic [KEY_W-1:0]  r_key;
    logic [ADDR_W-1:0] r_addr;

    logic [KEY_W-1:0]  c_key  [CAPACITY];
    logic [ADDR_W-1:0] c_addr [CAPACITY];
    logic [CAPACITY-1:0] c_lt;
    logic [CAPACITY-1:0] c_hit;
    logic [CAPACITY-1:0] c_valid;

    logic              hit;
    logic              full;
    logic              ins_ok;
    logic              rem_ok;
    logic [ADDR_W-1:0] hit_addr;
    t_status           n_status;
    logic [ADDR_W-1:0] n_found;
    t_cell_ctrl        ctrl;
    logic              accept;

    assign accept = i_start && !o_busy;
    assign o_busy = r_cmp;

    always_comb begin
        hit      = |c_hit;
        hit_addr = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (c_hit[i]) begin
                hit_addr = hit_addr | c_addr[i];
            end
        end
    end

    assign full   = (r_fill >= CNT_W'(CAPACITY));
    assign ins_ok = r_apply && (r_func == FUNC_INSERT) && !(r_unique && hit) && !full;
    assign rem_ok = r_apply && (r_func == FUNC_REMOVE) && hit;

    always_comb begin
        n_status = ST_OK;
        n_found  = '0;
        n_fill   = r_fill;
        unique case (r_func)
            FUNC_INSERT: begin
                if (r_unique && hit) begin
                    n_status = ST_DUP;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            FUNC_REMOVE: begin
                if (!hit) begin
                    n_status = ST_MISS;
                end else begin
                    n_fill = r_fill - CNT_W'(1);
                end
            end
            FUNC_SEARCH: begin
                if (!hit) begin
                    n_status = ST_MISS;
                end else begin
                    n_found = hit_addr;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unique <= 1'b1;
            r_cmp    <= 1'b0;
            r_apply  <= 1'b0;
            r_fill   <= '0;
            o_done   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unique <= i_cfg_wdata;
            end
            r_cmp   <= accept;
            r_apply <= r_cmp;
            o_done  <= r_apply;
            if (r_apply) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_key  <= normalize_key(i_key);
            r_addr <= i_record_address;
        end
        if (r_apply) begin
            o_status        <= n_status;
            o_found_address <= n_found;
            o_entry_count   <= to_entry_count(n_fill);
        end
    end

    assign ctrl.key  = r_key;
    assign ctrl.addr = r_addr;
    assign ctrl.cmp  = r_cmp;
    assign ctrl.ins  = ins_ok;
    assign ctrl.rem  = rem_ok;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic              left_lt;
        logic [KEY_W-1:0]  left_key;
        logic [ADDR_W-1:0] left_addr;
        logic [KEY_W-1:0]  right_key;
        logic [ADDR_W-1:0] right_addr;

        assign c_valid[i] = (r_fill > CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_lt   = 1'b1;
            assign left_key  = '0;
            assign left_addr = '0;
        end else begin : g_mid_l
            assign left_lt   = c_lt[i-1];
            assign left_key  = c_key[i-1];
            assign left_addr = c_addr[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_key  = '0;
            assign right_addr = '0;
        end else begin : g_mid_r
            assign right_key  = c_key[i+1];
            assign right_addr = c_addr[i+1];
        end

        skit_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_valid      (c_valid[i]),
            .i_left_lt    (left_lt),
            .i_left_key   (left_key),
            .i_left_addr  (left_addr),
            .i_right_key  (right_key),
            .i_right_addr (right_addr),
            .o_key        (c_key[i]),
            .o_addr       (c_addr[i]),
            .o_lt         (c_lt[i]),
            .o_hit        (c_hit[i])
        );
    end

`include "sorted_key_index_table_assert.svh"

    `SKIT_NEVER(a_fill_bound, r_fill > CNT_W'(CAPACITY), "fill count above capacity")
    `SKIT_ASSERT(a_accept_cmp, accept |=> r_cmp && !r_apply, "accepted transaction not compared")
    `SKIT_ASSERT(a_cmp_result, r_cmp |=> ##1 o_done, "compare not followed by a result")
    `SKIT_ASSERT(a_hit_single, r_apply |-> $onehot0(c_hit), "more than one cell reports a match")

endmodule

>>> rtl/skit_cell.sv
// One table slot: holds a key and address, compares, and shifts with its neighbours
module skit_cell (
    input  logic                     i_clk,
    input  skit_pkg::t_cell_ctrl     i_ctrl,
    input  logic                     i_valid,
    input  logic                     i_left_lt,
    input  logic [skit_pkg::KEY_W-1:0]  i_left_key,
    input  logic [skit_pkg::ADDR_W-1:0] i_left_addr,
    input  logic [skit_pkg::KEY_W-1:0]  i_right_key,
    input  logic [skit_pkg::ADDR_W-1:0] i_right_addr,
    output logic [skit_pkg::KEY_W-1:0]  o_key,
    output logic [skit_pkg::ADDR_W-1:0] o_addr,
    output logic                     o_lt,
    output logic                     o_hit
);
    import skit_pkg::*;

    logic [KEY_W-1:0]  r_key;
    logic [ADDR_W-1:0] r_addr;
    logic              r_lt;
    logic              r_eq;
    logic [KEY_W-1:0]  n_key;
    logic [ADDR_W-1:0] n_addr;

    always_comb begin
        n_key  = r_key;
        n_addr = r_addr;
        if (i_ctrl.ins && !r_lt) begin
            if (i_left_lt) begin
                n_key  = i_ctrl.key;
                n_addr = i_ctrl.addr;
            end else begin
                n_key  = i_left_key;
                n_addr = i_left_addr;
            end
        end else if (i_ctrl.rem && !r_lt) begin
            n_key  = i_right_key;
            n_addr = i_right_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_addr <= n_addr;
        if (i_ctrl.cmp) begin
            r_lt <= i_valid && (r_key < i_ctrl.key);
            r_eq <= (r_key == i_ctrl.key);
        end
    end

    assign o_key  = r_key;
    assign o_addr = r_addr;
    assign o_lt   = r_lt;
    assign o_hit  = !r_lt && i_left_lt && i_valid && r_eq;

endmodule

>>> tb/tb_sorted_key_index_table.sv
// Self-checking testbench for the sorted key index table: directed and random command traffic
module tb_sorted_key_index_table;
    timeunit 1ns;
    timeprecision 1ps;

    import skit_pkg::*;

    localparam int IDLE_LIMIT = 500;
    localparam int POOL_SIZE  = 16;

    typedef struct packed {
        t_status     status;
        logic [30:0] addr;
        logic [6:0]  count;
    } t_result;

    class key_index_tracker;
        logic [63:0]  key_mem [CAPACITY];
        logic [30:0]  addr_mem [CAPACITY];
        int unsigned  fill;
        bit           uniq_mode;
        t_result      pending_results [$];
        int unsigned  errors;

        function void clear();
            fill = 0;
            uniq_mode = 1'b1;
            pending_results.delete();
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function logic [63:0] norm_key(logic [63:0] raw);
            logic [63:0] k;
            k = '0;
            for (int b = 7; b >= 8 - KEY_BYTES; b--) begin
                if (raw[8*b +: 8] == 8'h00) break;
                k[8*b +: 8] = raw[8*b +: 8];
            end
            return k;
        endfunction

        function void note_command(logic [1:0] f, logic [63:0] raw, logic [30:0] a);
            logic [63:0] k;
            int unsigned pos;
            bit          hit;
            t_result     r;
            k = norm_key(raw);
            pos = 0;
            while (pos < fill && key_mem[pos] < k) pos++;
            hit = (pos < fill) && (key_mem[pos] == k);
            r.status = ST_OK;
            r.addr = '0;
            unique case (f)
                FUNC_INSERT: begin
                    if (uniq_mode && hit) begin
                        r.status = ST_DUP;
                    end else if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = fill; i > pos; i--) begin
                            key_mem[i] = key_mem[i-1];
                            addr_mem[i] = addr_mem[i-1];
                        end
                        key_mem[pos] = k;
                        addr_mem[pos] = a;
                        fill++;
                    end
                end
                FUNC_REMOVE: begin
                    if (!hit) begin
                        r.status = ST_MISS;
                    end else begin
                        for (int i = pos; i + 1 < fill; i++) begin
                            key_mem[i] = key_mem[i+1];
                            addr_mem[i] = addr_mem[i+1];
                        end
                        fill--;
                    end
                end
                FUNC_SEARCH: begin
                    if (!hit) begin
                        r.status = ST_MISS;
                    end else begin
                        r.addr = addr_mem[pos];
                    end
                end
                default: begin
                end
            endcase
            r.count = 7'(fill);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [30:0] fa, logic [6:0] cnt);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: status %0d addr %h count %0d", st, fa, cnt);
                end
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status || fa !== want.addr || cnt !== want.count) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: status %0d/%0d addr %h/%h count %0d/%0d (exp/act)",
                             want.status, st, want.addr, fa, want.count, cnt);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_func;
    logic [63:0] i_key;
    logic [30:0] i_record_address;
    logic        o_done;
    logic [1:0]  o_status;
    logic [30:0] o_found_address;
    logic [6:0]  o_entry_count;

    key_index_tracker tracker;
    int               burst_left;
    int               quiet_cycles;
    logic [63:0]      key_pool [POOL_SIZE];
    int               pool_len [POOL_SIZE];

    sorted_key_index_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_func           (i_func),
        .i_key            (i_key),
        .i_record_address (i_record_address),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_found_address  (o_found_address),
        .o_entry_count    (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tracker.clear();
            quiet_cycles = 0;
        end else begin
            if (i_cfg_we) tracker.uniq_mode = i_cfg_wdata;
            if (i_start && !o_busy) tracker.note_command(i_func, i_key, i_record_address);
            if (o_done) tracker.check_result(o_status, o_found_address, o_entry_count);
            if ((i_start && !o_busy) || o_done) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // a string of len characters, a terminator when len is under 8, then random bytes after it
    function automatic logic [63:0] make_string(int len, int lo, int hi);
        logic [63:0] k;
        k = {$urandom(), $urandom()};
        for (int b = 0; b < 8; b++) begin
            if (b < len) k[63-8*b -: 8] = 8'($urandom_range(hi, lo));
            else if (b == len) k[63-8*b -: 8] = 8'h00;
        end
        return k;
    endfunction

    function automatic logic [63:0] pick_key();
        int          r;
        int          idx;
        logic [63:0] tail;
        r = $urandom_range(99, 0);
        if (r < 60) begin
            idx = $urandom_range(POOL_SIZE - 1, 0);
            tail = (pool_len[idx] < 7) ? (64'h1 << (8 * (7 - pool_len[idx]))) - 64'h1 : '0;
            if ($urandom_range(1, 0) != 0) return key_pool[idx] | ({$urandom(), $urandom()} & tail);
            return key_pool[idx];
        end else if (r < 80) begin
            return make_string($urandom_range(8, 0), 1, 255);
        end else if (r < 95) begin
            return {$urandom(), $urandom()};
        end
        case ($urandom_range(2, 0))
            0: return 64'h0;
            1: return '1;
            default: return 64'h0100_0000_0000_0000;
        endcase
    endfunction

    function automatic t_func pick_func(int ins_w, int rem_w, int srch_w);
        int r;
        r = $urandom_range(99, 0);
        if (r < ins_w) return FUNC_INSERT;
        if (r < ins_w + rem_w) return FUNC_REMOVE;
        if (r < ins_w + rem_w + srch_w) return FUNC_SEARCH;
        return FUNC_NOP;
    endfunction

    task automatic issue(input logic [1:0] f, input logic [63:0] k, input logic [30:0] a);
        i_start <= 1'b1;
        i_func <= f;
        i_key <= k;
        i_record_address <= a;
        do @(posedge i_clk); while (o_busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(15, 0);
            if ($urandom_range(3, 0) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_unique(input logic v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int ins_w, int rem_w, int srch_w);
        for (int i = 0; i < n; i++) begin
            issue(pick_func(ins_w, rem_w, srch_w), pick_key(), 31'($urandom()));
        end
    endtask

    initial begin
        tracker = new();
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_start <= 1'b0;
        i_func <= FUNC_NOP;
        i_key <= '0;
        i_record_address <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = (i < 12) ? $urandom_range(3, 1) : $urandom_range(8, 4);
            key_pool[i] = tracker.norm_key(make_string(pool_len[i], 65, 70));
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, no-op, the key extremes and normalisation, then duplicates with unique keys off
        issue(FUNC_SEARCH, 64'h4100_0000_0000_0000, 31'd5);
        issue(FUNC_REMOVE, 64'h4100_0000_0000_0000, 31'd5);
        issue(FUNC_NOP,    64'h4100_0000_0000_0000, 31'h7FFF_FFFF);
        issue(FUNC_INSERT, 64'h0, 31'h7FFF_FFFF);
        issue(FUNC_INSERT, '1, 31'd0);
        issue(FUNC_INSERT, 64'h4200_0000_0000_0000, 31'd1);
        issue(FUNC_INSERT, 64'h4200_FFFF_FFFF_FFFF, 31'd2);
        issue(FUNC_INSERT, 64'h4241_0000_0000_0000, 31'd3);
        issue(FUNC_INSERT, 64'h4100_0000_0000_0000, 31'd4);
        issue(FUNC_SEARCH, 64'h4100_1234_5678_9ABC, 31'd0);
        issue(FUNC_SEARCH, '1, 31'h7FFF_FFFF);
        issue(FUNC_SEARCH, 64'h0, 31'd0);
        issue(FUNC_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 31'd0);
        issue(FUNC_NOP,    64'h4100_0000_0000_0000, 31'd9);
        issue(FUNC_REMOVE, 64'h4241_0000_0000_0000, 31'd0);
        issue(FUNC_SEARCH, 64'h4241_0000_0000_0000, 31'd0);
        issue(FUNC_REMOVE, 64'h0, 31'd0);
        issue(FUNC_REMOVE, 64'h00AB_CDEF_0000_0000, 31'd0);
        write_unique(1'b0);
        issue(FUNC_INSERT, 64'h4200_0000_0000_0000, 31'd3);
        issue(FUNC_SEARCH, 64'h4200_0000_0000_0000, 31'd0);
        issue(FUNC_INSERT, 64'h4200_5555_0000_0000, 31'd4);
        issue(FUNC_REMOVE, 64'h4200_0000_0000_0000, 31'd0);
        issue(FUNC_SEARCH, 64'h4200_0000_0000_0000, 31'd0);

        // fill to capacity; duplicates and a full table then meet
        write_unique(1'b1);
        run_phase(100, 88, 2, 8);
        write_unique(1'b0);
        run_phase(190, 45, 25, 25);
        write_unique(1'b1);
        run_phase(180, 22, 50, 24);
        write_unique(1'b0);
        run_phase(180, 35, 30, 30);

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
